/* rtl/msg_pkg.sv */
// Shared constants, types and the channel blend function of the gradient color unit.
package msg_pkg;

  // Gradient geometry
  localparam int MAX_STOPS     = 8;
  localparam int POS_BITS      = 16;
  localparam int STOP_SLOTS    = 8;
  localparam int STOP_IDX_BITS = $clog2(STOP_SLOTS);
  localparam int SEG_BITS      = $clog2(MAX_STOPS);
  localparam int FRAC_BITS     = 8;
  localparam int Q_BITS        = SEG_BITS + FRAC_BITS;
  localparam int SC_BITS       = POS_BITS + SEG_BITS;

  // Register and color field widths
  localparam int CHAN_BITS     = 8;
  localparam int COLOR_BITS    = 3 * CHAN_BITS;
  localparam int SPAN_BITS     = 16;
  localparam int CNT_BITS      = 4;
  localparam int PAIR_BITS     = 2 * COLOR_BITS;
  localparam int APB_DATA_BITS = 64;
  localparam int APB_ADDR_BITS = 6;
  localparam int REG_IDX_LSB   = 3;

  typedef enum logic [1:0] {
    MODE_BLACK,
    MODE_STOP0,
    MODE_BLEND
  } msg_mode_e;

  typedef enum logic [2:0] {
    REG_SPAN_START,
    REG_SPAN_END,
    REG_STOP_COUNT,
    REG_PAIR_A,
    REG_PAIR_B,
    REG_PAIR_C,
    REG_PAIR_D
  } msg_reg_e;

  typedef struct packed {
    logic [SPAN_BITS-1:0] span_start;
    logic [SPAN_BITS-1:0] span_end;
    logic [CNT_BITS-1:0]  stop_count;
  } msg_cfg_t;

  // Transaction as it moves down the divider row: remainder and quotient/numerator shifter
  typedef struct packed {
    msg_mode_e            mode;
    logic [SEG_BITS-1:0]  segs;
    logic [POS_BITS-1:0]  rem;
    logic [Q_BITS-1:0]    quo;
  } msg_div_t;

  // a + floor((b - a) * frac / 256), kept to 8 bits
  function automatic logic [CHAN_BITS-1:0] msg_blend_chan(
    input logic [CHAN_BITS-1:0] a,
    input logic [CHAN_BITS-1:0] b,
    input logic [FRAC_BITS-1:0] frac
  );
    logic signed [CHAN_BITS:0]             d;
    logic signed [CHAN_BITS+FRAC_BITS+1:0] p;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = d * $signed({1'b0, frac});
    return a + p[CHAN_BITS+FRAC_BITS-1:FRAC_BITS];
  endfunction

endpackage

/* rtl/msg_scale.sv */
// Front cells: clamp the position into the span, then scale it by the segment count.
module msg_scale import msg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [POS_BITS-1:0] pos_i,
  input  msg_cfg_t            cfg_i,
  input  logic [POS_BITS-1:0] range_i,
  output logic                valid_o,
  input  logic                ready_i,
  output msg_div_t            data_o
);

  typedef struct packed {
    msg_mode_e           mode;
    logic [SEG_BITS-1:0] segs;
    logic [POS_BITS-1:0] rel;
  } msg_rel_t;

  logic                s1_v_q;
  msg_rel_t            s1_q, s1_d;
  logic                s1_ready;
  logic                s2_v_q;
  msg_div_t            s2_q, s2_d;
  logic                s2_ready;

  logic [CNT_BITS-1:0] count;
  logic [POS_BITS-1:0] start_pos;
  logic [POS_BITS-1:0] last_pos;
  logic [POS_BITS-1:0] rel;
  logic [SC_BITS-1:0]  scaled;

  // Clamp count and position, pick the mode
  always_comb begin
    start_pos = POS_BITS'(cfg_i.span_start);
    last_pos  = POS_BITS'(cfg_i.span_end);
    count     = (cfg_i.stop_count > CNT_BITS'(MAX_STOPS)) ? CNT_BITS'(MAX_STOPS)
                                                          : cfg_i.stop_count;
    rel       = (pos_i < start_pos) ? '0 : pos_i - start_pos;
    if (rel >= range_i) begin
      rel = range_i - 1'b1;
    end
    s1_d.rel  = rel;
    s1_d.segs = SEG_BITS'(count - 1'b1);
    priority if (count == '0) begin
      s1_d.mode = MODE_BLACK;
    end else if (count == CNT_BITS'(1) || last_pos <= start_pos) begin
      s1_d.mode = MODE_STOP0;
    end else begin
      s1_d.mode = MODE_BLEND;
    end
  end

  // Scale by the segment count and load the divider shifter
  always_comb begin
    scaled      = SC_BITS'(s1_q.rel) * SC_BITS'(s1_q.segs);
    s2_d.mode   = s1_q.mode;
    s2_d.segs   = s1_q.segs;
    s2_d.rem    = scaled[SC_BITS-1:SEG_BITS];
    s2_d.quo    = {scaled[SEG_BITS-1:0], FRAC_BITS'(0)};
  end

  assign s2_ready = !s2_v_q || ready_i;
  assign s1_ready = !s1_v_q || s2_ready;
  assign ready_o  = s1_ready;
  assign valid_o  = s2_v_q;
  assign data_o   = s2_q;

  // Advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= valid_i;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (s1_ready && valid_i) begin
      s1_q <= s1_d;
    end
    if (s2_ready && s1_v_q) begin
      s2_q <= s2_d;
    end
  end

  a_blend_has_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && s1_q.mode == MODE_BLEND |-> s1_q.segs != '0)
    else $error("blend transaction with no segment");

endmodule

/* rtl/msg_div_cell.sv */
// One restoring-division cell: produces one quotient bit per transaction and passes it on.
module msg_div_cell import msg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  msg_div_t            data_i,
  input  logic [POS_BITS-1:0] range_i,
  output logic                valid_o,
  input  logic                ready_i,
  output msg_div_t            data_o
);

  logic              v_q;
  msg_div_t          data_q, data_d;
  logic [POS_BITS:0] rem_sh;
  logic [POS_BITS:0] diff;

  // Shift in the next numerator bit, subtract the divisor when it fits
  always_comb begin
    rem_sh   = {data_i.rem, data_i.quo[Q_BITS-1]};
    diff     = rem_sh - {1'b0, range_i};
    data_d   = data_i;
    data_d.quo = {data_i.quo[Q_BITS-2:0], 1'b0};
    if (rem_sh >= {1'b0, range_i}) begin
      data_d.rem    = diff[POS_BITS-1:0];
      data_d.quo[0] = 1'b1;
    end else begin
      data_d.rem    = rem_sh[POS_BITS-1:0];
    end
  end

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;
  assign data_o  = data_q;

  // Advance valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

/* rtl/msg_blend.sv */
// Back cells: pick the segment's end stops, then interpolate each channel into the output register.
module msg_blend import msg_pkg::*; (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  msg_div_t                             data_i,
  input  logic [STOP_SLOTS-1:0][COLOR_BITS-1:0] stops_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic [CHAN_BITS-1:0]                 red_o,
  output logic [CHAN_BITS-1:0]                 green_o,
  output logic [CHAN_BITS-1:0]                 blue_o
);

  typedef struct packed {
    logic                  blend;
    logic [COLOR_BITS-1:0] c1;
    logic [COLOR_BITS-1:0] c2;
    logic [FRAC_BITS-1:0]  frac;
  } msg_pick_t;

  logic                  a_v_q;
  msg_pick_t             a_q, a_d;
  logic                  a_ready;
  logic                  o_v_q;
  logic [COLOR_BITS-1:0] o_q, o_d;
  logic                  o_ready;

  logic [SEG_BITS-1:0]   seg;
  logic [SEG_BITS-1:0]   seg_nxt;
  logic [FRAC_BITS-1:0]  frac;

  // Split the quotient, clamp to the last segment, select stops
  always_comb begin
    seg  = data_i.quo[Q_BITS-1:FRAC_BITS];
    frac = data_i.quo[FRAC_BITS-1:0];
    if (seg >= data_i.segs) begin
      seg  = data_i.segs - 1'b1;
      frac = '1;
    end
    seg_nxt = seg + 1'b1;
    a_d = '0;
    unique case (data_i.mode)
      MODE_BLACK: begin
        a_d = '0;
      end
      MODE_STOP0: begin
        a_d.c1 = stops_i[0];
        a_d.c2 = stops_i[0];
      end
      MODE_BLEND: begin
        a_d.blend = 1'b1;
        a_d.c1    = stops_i[STOP_IDX_BITS'(seg)];
        a_d.c2    = stops_i[STOP_IDX_BITS'(seg_nxt)];
        a_d.frac  = frac;
      end
      default: begin
        a_d = '0;
      end
    endcase
  end

  // Interpolate each channel
  always_comb begin
    o_d[CHAN_BITS-1:0] =
      msg_blend_chan(a_q.c1[CHAN_BITS-1:0], a_q.c2[CHAN_BITS-1:0], a_q.frac);
    o_d[2*CHAN_BITS-1:CHAN_BITS] =
      msg_blend_chan(a_q.c1[2*CHAN_BITS-1:CHAN_BITS], a_q.c2[2*CHAN_BITS-1:CHAN_BITS], a_q.frac);
    o_d[COLOR_BITS-1:2*CHAN_BITS] =
      msg_blend_chan(a_q.c1[COLOR_BITS-1:2*CHAN_BITS], a_q.c2[COLOR_BITS-1:2*CHAN_BITS],
                     a_q.frac);
  end

  assign o_ready = !o_v_q || ready_i;
  assign a_ready = !a_v_q || o_ready;
  assign ready_o = a_ready;
  assign valid_o = o_v_q;
  assign red_o   = o_q[CHAN_BITS-1:0];
  assign green_o = o_q[2*CHAN_BITS-1:CHAN_BITS];
  assign blue_o  = o_q[COLOR_BITS-1:2*CHAN_BITS];

  // Advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_v_q <= valid_i;
      end
      if (o_ready) begin
        o_v_q <= a_v_q;
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      a_q <= a_d;
    end
    if (o_ready && a_v_q) begin
      o_q <= o_d;
    end
  end

  a_flat_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_v_q && !a_q.blend |-> a_q.c1 == a_q.c2)
    else $error("non-blend transaction carries two different stops");

endmodule

/* rtl/multi_stop_gradient_color_unit.sv */
// Top level of the multi-stop gradient color unit: register file and the row of cells.
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+-----------------------------
//  input    | in_valid_i / in_ready_o          | char_position_i[15:0]
//  output   | out_valid_o / out_ready_i        | red_o, green_o, blue_o [7:0]
//  config   | psel, penable, pwrite / pready   | paddr[5:0] (8*index), pwdata/prdata[63:0]
//
// One transaction enters per cycle unless the output stalls; each result passes through
// two front cells (clamp, scale), eleven divider cells with one quotient bit each, and two
// back cells (stop select, blend into the output register).
// Reset clears the configuration registers and the valid flags, which empties the row;
// no clearing pass is needed.
// A stalled output holds its cell; a cell takes a new transaction whenever it is empty or
// its neighbor advances, so bubbles in the row are squeezed out under stall.
module multi_stop_gradient_color_unit import msg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [SPAN_BITS-1:0]     char_position_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [CHAN_BITS-1:0]     red_o,
  output logic [CHAN_BITS-1:0]     green_o,
  output logic [CHAN_BITS-1:0]     blue_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  logic [SPAN_BITS-1:0] span_start_q;
  logic [SPAN_BITS-1:0] span_end_q;
  logic [CNT_BITS-1:0]  stop_count_q;
  logic [PAIR_BITS-1:0] pair_a_q;
  logic [PAIR_BITS-1:0] pair_b_q;
  logic [PAIR_BITS-1:0] pair_c_q;
  logic [PAIR_BITS-1:0] pair_d_q;

  msg_reg_e                             reg_idx;
  logic                                 cfg_wr;
  msg_cfg_t                             cfg;
  logic [POS_BITS-1:0]                  range_len;
  logic [STOP_SLOTS-1:0][COLOR_BITS-1:0] stops;

  logic     div_valid [Q_BITS+1];
  logic     div_ready [Q_BITS+1];
  msg_div_t div_data  [Q_BITS+1];

  // Decode the register port
  assign reg_idx = msg_reg_e'(paddr[APB_ADDR_BITS-1:REG_IDX_LSB]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_start_q <= '0;
      span_end_q   <= '0;
      stop_count_q <= '0;
      pair_a_q     <= '0;
      pair_b_q     <= '0;
      pair_c_q     <= '0;
      pair_d_q     <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SPAN_START: span_start_q <= pwdata[SPAN_BITS-1:0];
        REG_SPAN_END:   span_end_q   <= pwdata[SPAN_BITS-1:0];
        REG_STOP_COUNT: stop_count_q <= pwdata[CNT_BITS-1:0];
        REG_PAIR_A:     pair_a_q     <= pwdata[PAIR_BITS-1:0];
        REG_PAIR_B:     pair_b_q     <= pwdata[PAIR_BITS-1:0];
        REG_PAIR_C:     pair_c_q     <= pwdata[PAIR_BITS-1:0];
        REG_PAIR_D:     pair_d_q     <= pwdata[PAIR_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Return register contents
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_SPAN_START: prdata = APB_DATA_BITS'(span_start_q);
      REG_SPAN_END:   prdata = APB_DATA_BITS'(span_end_q);
      REG_STOP_COUNT: prdata = APB_DATA_BITS'(stop_count_q);
      REG_PAIR_A:     prdata = APB_DATA_BITS'(pair_a_q);
      REG_PAIR_B:     prdata = APB_DATA_BITS'(pair_b_q);
      REG_PAIR_C:     prdata = APB_DATA_BITS'(pair_c_q);
      REG_PAIR_D:     prdata = APB_DATA_BITS'(pair_d_q);
      default:        prdata = '0;
    endcase
  end

  // Span length and stop table seen by the cells
  assign cfg.span_start = span_start_q;
  assign cfg.span_end   = span_end_q;
  assign cfg.stop_count = stop_count_q;
  assign range_len      = POS_BITS'(span_end_q) - POS_BITS'(span_start_q);
  assign stops          = {pair_d_q, pair_c_q, pair_b_q, pair_a_q};

  msg_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .pos_i   (POS_BITS'(char_position_i)),
    .cfg_i   (cfg),
    .range_i (range_len),
    .valid_o (div_valid[0]),
    .ready_i (div_ready[0]),
    .data_o  (div_data[0])
  );

  // Row of divider cells, one quotient bit each
  for (genvar k = 0; k < Q_BITS; k++) begin : g_div
    msg_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_valid[k]),
      .ready_o (div_ready[k]),
      .data_i  (div_data[k]),
      .range_i (range_len),
      .valid_o (div_valid[k+1]),
      .ready_i (div_ready[k+1]),
      .data_o  (div_data[k+1])
    );
  end

  msg_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid[Q_BITS]),
    .ready_o (div_ready[Q_BITS]),
    .data_i  (div_data[Q_BITS]),
    .stops_i (stops),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

  a_empty_output_takes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("row stalls with an empty output register");

endmodule

/* sim/tb_multi_stop_gradient_color_unit.sv */
// Self-checking testbench of the multi-stop gradient color unit.
`timescale 1ns / 100ps

module tb_multi_stop_gradient_color_unit;
  import msg_pkg::*;

  localparam int          MAX_GAP         = 18;
  localparam int          LONG_HOLD       = 300;
  localparam int          NUM_PHASES      = 10;
  localparam int          ITEMS_PER_PHASE = 85;
  localparam int          DRAIN_CYCLES    = 40;
  localparam int          CYCLE_LIMIT     = 300000;
  localparam int          REPORT_LIMIT    = 10;
  localparam logic [2:0]  REG_UNMAPPED    = 3'd7;
  localparam logic [23:0] STOP0_COLOR     = 24'h3C960A;

  typedef struct packed {
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
  } rgb_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct {
    row_kind_e       kind;
    logic [2:0]      reg_idx;
    logic [63:0]     value;
    logic [15:0]     pos;
    bit              typed;
    rgb_t            rgb;
  } stim_row_t;

  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     in_valid_i      = 1'b0;
  logic                     in_ready_o;
  logic [SPAN_BITS-1:0]     char_position_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i     = 1'b0;
  logic [CHAN_BITS-1:0]     red_o;
  logic [CHAN_BITS-1:0]     green_o;
  logic [CHAN_BITS-1:0]     blue_o;
  logic                     psel            = 1'b0;
  logic                     penable         = 1'b0;
  logic                     pwrite          = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr           = '0;
  logic [APB_DATA_BITS-1:0] pwdata          = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  // Predictor copy of the register file
  logic [SPAN_BITS-1:0]  cfg_span_start = '0;
  logic [SPAN_BITS-1:0]  cfg_span_end   = '0;
  logic [CNT_BITS-1:0]   cfg_stop_count = '0;
  logic [COLOR_BITS-1:0] stop_palette [STOP_SLOTS];

  rgb_t       expected_colors [$];
  stim_row_t  stim_rows [$];
  int         fail_count    = 0;
  int         cycle_count   = 0;
  int         stall_left    = 0;
  bit         tx_calm       = 1'b0;
  bit         rx_calm       = 1'b0;
  bit         long_hold_req = 1'b0;
  bit         took_result   = 1'b0;

  multi_stop_gradient_color_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .char_position_i (char_position_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    for (int k = 0; k < STOP_SLOTS; k++) stop_palette[k] = '0;
  end

  // Split a packed stop (R low byte, G, B) into channels
  function automatic rgb_t rgb_of(input logic [COLOR_BITS-1:0] c);
    rgb_t r;
    r.red   = c[7:0];
    r.green = c[15:8];
    r.blue  = c[23:16];
    return r;
  endfunction

  // a + floor((b - a) * frac / 256), wrapped to 8 bits
  function automatic logic [CHAN_BITS-1:0] blend_channel(input logic [CHAN_BITS-1:0] a,
                                                         input logic [CHAN_BITS-1:0] b,
                                                         input int unsigned frac);
    int ai;
    int bi;
    int prod;
    int sum;
    ai   = a;
    bi   = b;
    prod = (bi - ai) * int'(frac);
    sum  = ai + (prod >>> FRAC_BITS);
    return sum[CHAN_BITS-1:0];
  endfunction

  // Color of one character position under the current register settings
  function automatic rgb_t gradient_color(input logic [SPAN_BITS-1:0] pos);
    int unsigned     count;
    int unsigned     range;
    int unsigned     rel;
    int unsigned     segs;
    int unsigned     scaled;
    int unsigned     seg;
    int unsigned     frac;
    logic [COLOR_BITS-1:0] c1;
    logic [COLOR_BITS-1:0] c2;
    msg_mode_e       mode;
    rgb_t            res;
    count = (cfg_stop_count > MAX_STOPS) ? MAX_STOPS : cfg_stop_count;
    if (count == 0) mode = MODE_BLACK;
    else if (count == 1 || cfg_span_end <= cfg_span_start) mode = MODE_STOP0;
    else mode = MODE_BLEND;
    case (mode)
      MODE_BLACK: res = '0;
      MODE_STOP0: res = rgb_of(stop_palette[0]);
      default: begin
        range = cfg_span_end - cfg_span_start;
        rel   = (pos < cfg_span_start) ? 0 : pos - cfg_span_start;
        if (rel >= range) rel = range - 1;
        segs   = count - 1;
        scaled = rel * segs;
        seg    = scaled / range;
        frac   = ((scaled % range) * 256) / range;
        // Segment past the end: hold the last segment at full fraction
        if (seg >= segs) begin
          seg  = segs - 1;
          frac = 255;
        end
        c1 = stop_palette[seg % STOP_SLOTS];
        c2 = stop_palette[(seg + 1) % STOP_SLOTS];
        res.red   = blend_channel(c1[7:0],   c2[7:0],   frac);
        res.green = blend_channel(c1[15:8],  c2[15:8],  frac);
        res.blue  = blend_channel(c1[23:16], c2[23:16], frac);
      end
    endcase
    return res;
  endfunction

  // Mirror a register write into the predictor
  function automatic void apply_register_write(input logic [2:0] idx, input logic [63:0] value);
    int unsigned k;
    case (idx)
      REG_SPAN_START: cfg_span_start = value[SPAN_BITS-1:0];
      REG_SPAN_END:   cfg_span_end   = value[SPAN_BITS-1:0];
      REG_STOP_COUNT: cfg_stop_count = value[CNT_BITS-1:0];
      REG_PAIR_A, REG_PAIR_B, REG_PAIR_C, REG_PAIR_D: begin
        k = (idx - REG_PAIR_A) * 2;
        stop_palette[k]     = value[COLOR_BITS-1:0];
        stop_palette[k + 1] = value[PAIR_BITS-1:COLOR_BITS];
      end
      default: ;
    endcase
  endfunction

  // Pick a position: mostly inside the span, some at its borders, some anywhere
  function automatic logic [SPAN_BITS-1:0] pick_position(input int unsigned s,
                                                         input int unsigned e);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6 && e > s) return SPAN_BITS'(s + $urandom_range(0, e - s - 1));
    if (roll < 8) begin
      case ($urandom_range(0, 5))
        0: return SPAN_BITS'(s);
        1: return SPAN_BITS'(e - 1);
        2: return SPAN_BITS'(e);
        3: return SPAN_BITS'(s - 1);
        4: return '0;
        default: return '1;
      endcase
    end
    return SPAN_BITS'($urandom);
  endfunction

  // Drain the row, then write one register through the APB port
  task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_colors.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_BITS'({idx, {REG_IDX_LSB{1'b0}}});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_register_write(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one position after a random gap and hold it until accepted
  task automatic send_position(input logic [SPAN_BITS-1:0] pos, input bit typed,
                               input rgb_t typed_rgb);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    char_position_i <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    expected_colors.push_back(typed ? typed_rgb : gradient_color(pos));
  endtask

  // Change idling of both sides between clock edges of the driving processes
  task automatic set_traffic(input bit tx_idle, input bit rx_idle, input bit hold);
    @(posedge clk_i);
    tx_calm = !tx_idle;
    rx_calm = !rx_idle;
    if (hold) long_hold_req = 1'b1;
  endtask

  task automatic add_cfg(input logic [2:0] idx, input logic [63:0] value);
    stim_rows.push_back('{ROW_CFG, idx, value, '0, 1'b0, '0});
  endtask

  task automatic add_item(input logic [SPAN_BITS-1:0] pos);
    stim_rows.push_back('{ROW_ITEM, '0, '0, pos, 1'b0, '0});
  endtask

  task automatic add_item_typed(input logic [SPAN_BITS-1:0] pos, input rgb_t rgb);
    stim_rows.push_back('{ROW_ITEM, '0, '0, pos, 1'b1, rgb});
  endtask

  // Drive ready low for a drawn stall after each result, or for a long hold-off
  always @(negedge clk_i) begin
    if (long_hold_req) begin
      stall_left    = LONG_HOLD;
      long_hold_req = 1'b0;
      took_result   = 1'b0;
    end else if (took_result) begin
      stall_left  = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      took_result = 1'b0;
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each accepted color with the oldest expectation
  always @(posedge clk_i) begin : check_colors
    rgb_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      took_result = 1'b1;
      if (expected_colors.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected color r=%02h g=%02h b=%02h", red_o, green_o, blue_o);
      end else begin
        want = expected_colors.pop_front();
        if (red_o !== want.red || green_o !== want.green || blue_o !== want.blue) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("color mismatch: expected r=%02h g=%02h b=%02h, got r=%02h g=%02h b=%02h",
                     want.red, want.green, want.blue, red_o, green_o, blue_o);
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d colors outstanding",
               cycle_count, expected_colors.size());
      $display("FAIL multi_stop_gradient_color_unit");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned span_s;
    int unsigned span_e;
    int unsigned cnt;
    int unsigned style;
    int          mode;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: reset state, extremes and each corner of the mapping
    add_item_typed(16'h0000, '0);
    add_item_typed(16'hFFFF, '0);
    add_cfg(REG_PAIR_A, {16'h0000, 24'hFFFFFF, STOP0_COLOR});
    add_cfg(REG_PAIR_B, {16'hFFFF, 24'h000000, 24'hFF00FF});
    add_cfg(REG_PAIR_C, {16'h0000, 24'h123456, 24'h80FF01});
    add_cfg(REG_PAIR_D, {16'hFFFF, 24'h7F807F, 24'hFEDCBA});
    add_cfg(REG_SPAN_START, 64'h0100);
    add_cfg(REG_SPAN_END, 64'h0200);
    add_cfg(REG_STOP_COUNT, 64'd1);
    add_item_typed(16'h0150, rgb_of(STOP0_COLOR));
    add_item_typed(16'hFFFF, rgb_of(STOP0_COLOR));
    add_cfg(REG_STOP_COUNT, 64'd2);
    add_item_typed(16'h0100, rgb_of(STOP0_COLOR));
    add_item_typed(16'h0000, rgb_of(STOP0_COLOR));
    add_item(16'h01FF);
    add_item(16'hFFFF);
    add_item(16'h0180);
    add_cfg(REG_SPAN_START, 64'h0000);
    add_cfg(REG_SPAN_END, 64'hFFFF);
    add_cfg(REG_STOP_COUNT, 64'd8);
    add_item_typed(16'h0000, rgb_of(STOP0_COLOR));
    add_item(16'h8000);
    add_item(16'hFFFF);
    add_item(16'h2492);
    // Count above the maximum is treated as eight stops
    add_cfg(REG_STOP_COUNT, 64'd15);
    add_item(16'hC000);
    add_item(16'h6DB6);
    // Span ending before its start, then an empty span
    add_cfg(REG_SPAN_START, 64'h0200);
    add_cfg(REG_SPAN_END, 64'h0100);
    add_item_typed(16'h0180, rgb_of(STOP0_COLOR));
    add_cfg(REG_SPAN_END, 64'h0200);
    add_item_typed(16'h0200, rgb_of(STOP0_COLOR));
    add_cfg(REG_SPAN_START, 64'h01FF);
    add_item(16'hFFFF);
    // A write past the last register must change nothing
    add_cfg(REG_UNMAPPED, '1);
    add_item(16'h0000);
    add_cfg(REG_STOP_COUNT, 64'd0);
    add_item_typed(16'h1234, '0);
    add_cfg(REG_STOP_COUNT, 64'd3);
    add_cfg(REG_SPAN_START, 64'h0000);
    add_cfg(REG_SPAN_END, 64'h0003);
    add_item(16'h0001);
    add_item(16'h0002);

    set_traffic(1'b1, 1'b1, 1'b0);
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG)
        write_register(stim_rows[i].reg_idx, stim_rows[i].value);
      else
        send_position(stim_rows[i].pos, stim_rows[i].typed, stim_rows[i].rgb);
    end

    // Random phases: new settings, then a burst of positions
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      style = (phase == 0) ? 0 : $urandom_range(0, 5);
      case (style)
        0: begin
          span_s = 0;
          span_e = 16'hFFFF;
        end
        1: begin
          span_s = $urandom_range(0, 16'hFFF0);
          span_e = span_s + $urandom_range(1, 4);
        end
        2: begin
          span_s = $urandom_range(0, 16'hF000);
          span_e = span_s + $urandom_range(1, 16'h0FFF);
        end
        3: begin
          span_s = $urandom_range(0, 16'hFFFF);
          span_e = $urandom_range(0, 16'hFFFF);
        end
        4: begin
          span_s = $urandom_range(0, 16'hFFFF);
          span_e = span_s - $urandom_range(0, span_s);
        end
        default: begin
          span_s = $urandom_range(0, 16'h3FFF);
          span_e = $urandom_range(16'hC000, 16'hFFFF);
        end
      endcase
      if (phase == 0) cnt = 8;
      else if (phase == NUM_PHASES - 1) cnt = 15;
      else if ($urandom_range(0, 9) < 7) cnt = $urandom_range(2, 8);
      else cnt = $urandom_range(0, 15);

      write_register(REG_SPAN_START, 64'(span_s));
      write_register(REG_SPAN_END, 64'(span_e));
      write_register(REG_STOP_COUNT, 64'(cnt));
      for (int k = 0; k < 4; k++) write_register(3'(REG_PAIR_A + k), {$urandom, $urandom});
      if (phase % 2 == 1) write_register(REG_UNMAPPED, {$urandom, $urandom});

      // Rotate idling: both, neither, sender only, receiver only with a long hold-off
      mode = phase % 4;
      set_traffic(mode == 0 || mode == 2, mode == 0 || mode == 3, mode == 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_position(pick_position(span_s, span_e), 1'b0, '0);
    end

    // Drain and let any stray color surface
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS multi_stop_gradient_color_unit");
    end else begin
      $display("FAIL multi_stop_gradient_color_unit");
    end
    $finish;
  end

endmodule

/* multi_stop_gradient_color_unit.f */
rtl/msg_pkg.sv
rtl/msg_scale.sv
rtl/msg_div_cell.sv
rtl/msg_blend.sv
rtl/multi_stop_gradient_color_unit.sv
sim/tb_multi_stop_gradient_color_unit.sv
